[design/stsi_pkg.sv]
// ----------------------------------------------------------------------------
// stsi_pkg
// Shared types and codes for the sorted table: operation and status codes,
// and the control and flag groups passed between the top level and the cells.
// ----------------------------------------------------------------------------
package stsi_pkg;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_cmd_t;

    // compare flags reported by each cell
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cell_flags_t;

endpackage

[design/sorted_table_insert_remove_search_top.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_search_top
// Sorted table of signed 32-bit values held in a row of compare-and-shift
// cells. Each item searches, inserts in order or removes the first match.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  input    | s_valid s_ready s_mode s_value          | in
//  result   | m_valid m_ready m_match_count m_status  | out
//           | m_entries_held                          |
//
//  One item per cycle while m_ready holds: every cell compares and shifts in the
//  accept cycle, and the result is registered and shown in the next cycle.
//  The longest path is the 32-bit compare in each cell
//  followed by the count encode across CAPACITY cells.
//  The input is accepted whenever the result register is empty or being taken.
//  Reset (aresetn low, synchronous) empties the table and the result register.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_search_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic signed [31:0]            s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [stsi_pkg::COUNT_W-1:0]  m_match_count,
    output logic [1:0]                    m_status,
    output logic [stsi_pkg::COUNT_W-1:0]  m_entries_held
);
    import stsi_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_valid_reg;
    logic [COUNT_W-1:0] match_reg;
    logic [COUNT_W-1:0] match_next;
    status_t            status_reg;
    status_t            status_next;

    logic               accept;
    cell_cmd_t          cmd;
    value_t             entry   [CAPACITY];
    cell_flags_t        flags   [CAPACITY];
    logic [CAPACITY-1:0] valid;
    logic [CAPACITY:0]  lt_ext;
    logic [CAPACITY:0]  le_ext;
    logic [CAPACITY-1:0] eq_vec;
    logic [CNT_W-1:0]   n_lt;
    logic [CNT_W-1:0]   n_le;
    logic               found;
    logic               empty;
    logic               full;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign valid[g]  = CNT_W'(g) < count_reg;
            assign lt_ext[g] = flags[g].lt;
            assign le_ext[g] = !flags[g].gt;
            assign eq_vec[g] = flags[g].eq;

            stsi_cell u_cell (
                .aclk        (aclk),
                .valid       (valid[g]),
                .cmd         (cmd),
                .value       (s_value),
                .left_gt     ((g == 0) ? 1'b0 : flags[(g == 0) ? 0 : g-1].gt),
                .left_entry  (entry[(g == 0) ? 0 : g-1]),
                .right_entry (entry[(g == CAPACITY-1) ? g : g+1]),
                .entry       (entry[g]),
                .flags       (flags[g])
            );
        end
    endgenerate

    assign lt_ext[CAPACITY] = 1'b0;
    assign le_ext[CAPACITY] = 1'b0;

    // both flag rows are thermometers; the edge gives the number of cells below it
    always_comb begin
        n_lt = '0;
        n_le = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (lt_ext[i] && !lt_ext[i+1]) n_lt = n_lt | CNT_W'(i + 1);
            if (le_ext[i] && !le_ext[i+1]) n_le = n_le | CNT_W'(i + 1);
        end
    end

    assign found = |eq_vec;
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(CAPACITY));

    always_comb begin
        cmd         = '0;
        count_next  = count_reg;
        match_next  = '0;
        status_next = ST_DONE;
        unique case (s_mode)
            MODE_SEARCH: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!found) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    match_next = COUNT_W'(n_le - n_lt);
                end
            end
            MODE_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    cmd.insert = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!found) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    cmd.remove = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            match_reg  <= match_next;
            status_reg <= status_next;
        end
    end

    logic [COUNT_W-1:0] held_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= COUNT_W'(count_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_match_count  = match_reg;
    assign m_status       = status_reg;
    assign m_entries_held = held_reg;

endmodule

[design/stsi_cell.sv]
// ----------------------------------------------------------------------------
// stsi_cell
// One slot of the sorted table. Compares its entry with the broadcast value
// and, on insert, takes its left neighbour's entry or the value; on remove, its right neighbour's.
// ----------------------------------------------------------------------------
module stsi_cell (
    input  logic                aclk,
    input  logic                valid,
    input  stsi_pkg::cell_cmd_t cmd,
    input  stsi_pkg::value_t    value,
    input  logic                left_gt,
    input  stsi_pkg::value_t    left_entry,
    input  stsi_pkg::value_t    right_entry,
    output stsi_pkg::value_t    entry,
    output stsi_pkg::cell_flags_t flags
);
    import stsi_pkg::*;

    value_t entry_reg;
    value_t entry_next;

    assign entry = entry_reg;

    always_comb begin
        flags.lt = valid && (entry_reg < value);
        flags.eq = valid && (entry_reg == value);
        flags.gt = !valid || (entry_reg > value);
    end

    // insert: cells past the slot shift right; remove: cells from the match shift left
    always_comb begin
        entry_next = entry_reg;
        if (cmd.insert && flags.gt) begin
            entry_next = left_gt ? left_entry : value;
        end else if (cmd.remove && !flags.lt) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

[design/stsi_checker.sv]
// ----------------------------------------------------------------------------
// stsi_checker
// Port-level checks for the sorted table, bound to the top level.
// ----------------------------------------------------------------------------
module stsi_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [stsi_pkg::COUNT_W-1:0]  m_match_count,
    input  logic [1:0]                    m_status,
    input  logic [stsi_pkg::COUNT_W-1:0]  m_entries_held
);
    import stsi_pkg::*;

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_match_count))
        else $error("item dropped or changed while stalled");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_count_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_match_count != '0 |-> m_status == ST_DONE)
        else $error("match count with failing status");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL
            |-> m_entries_held == COUNT_W'(CAPACITY) && m_match_count == '0)
        else $error("full reported with wrong entry count");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sorted_table_insert_remove_search_top stsi_checker #(.CAPACITY(CAPACITY)) u_stsi_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_match_count  (m_match_count),
    .m_status       (m_status),
    .m_entries_held (m_entries_held)
);
